FILE: rtl/heu_pkg.sv
// heu_pkg: shared types, character constants and entity lookup functions
// for the html entity escaper. No dependencies.
`timescale 1ns / 1ps

package heu_pkg;

    // lookahead window depth and bytes examined per input transaction
    localparam int WIN_DEPTH = 3;
    localparam int SEQ_LEN   = WIN_DEPTH + 1;

    // raw characters the decision logic looks at
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // entity texts, left aligned in six bytes, first character in the top byte
    localparam logic [5:0][7:0] ENT_AMP  = {"&amp;", 8'h00};
    localparam logic [5:0][7:0] ENT_LT   = {"&lt;", 16'h0000};
    localparam logic [5:0][7:0] ENT_GT   = {"&gt;", 16'h0000};
    localparam logic [5:0][7:0] ENT_QUOT = "&quot;";
    localparam logic [5:0][7:0] ENT_APOS = {"&#39;", 8'h00};

    // how one decided byte expands on the output
    typedef enum logic [2:0] {
        K_PLAIN = 3'd0,
        K_AMP   = 3'd1,
        K_LT    = 3'd2,
        K_GT    = 3'd3,
        K_QUOT  = 3'd4,
        K_APOS  = 3'd5
    } t_kind;

    // decided tokens of one input transaction, already compacted
    typedef struct packed {
        logic                     last;
        logic [2:0]               cnt;
        t_kind [SEQ_LEN-1:0]      kind;
        logic [SEQ_LEN-1:0][7:0]  chr;
    } t_step_rec;

    // number of output bytes for one token
    function automatic logic [2:0] ent_len(input t_kind kind);
        logic [2:0] len;
        case (kind)
            K_PLAIN: len = 3'd1;
            K_AMP:   len = 3'd5;
            K_LT:    len = 3'd4;
            K_GT:    len = 3'd4;
            K_QUOT:  len = 3'd6;
            K_APOS:  len = 3'd5;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    // output byte at position idx of a token's expansion
    function automatic logic [7:0] ent_char(input t_kind kind, input logic [2:0] idx,
                                            input logic [7:0] chr);
        logic [5:0][7:0] txt;
        logic [7:0]      res;
        txt = ENT_AMP;
        case (kind)
            K_AMP:   txt = ENT_AMP;
            K_LT:    txt = ENT_LT;
            K_GT:    txt = ENT_GT;
            K_QUOT:  txt = ENT_QUOT;
            K_APOS:  txt = ENT_APOS;
            default: txt = ENT_AMP;
        endcase
        if (kind == K_PLAIN) begin
            res = chr;
        end else begin
            res = txt[3'(3'd5 - idx)];
        end
        return res;
    endfunction

endpackage

FILE: rtl/heu_in_if.sv
// heu_in_if: input byte stream channel, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface heu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/heu_out_if.sv
// heu_out_if: escaped byte stream channel, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface heu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;

    modport source (output valid, output out_byte, output has_byte, output end_of_string,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input end_of_string,
                    output ready);
endinterface

FILE: rtl/heu_cfg_if.sv
// heu_cfg_if: configuration write channel carrying the allow_html register.
// Depends on nothing.
`timescale 1ns / 1ps

interface heu_cfg_if;
    logic valid;
    logic ready;
    logic allow_html;

    modport source (output valid, output allow_html, input ready);
    modport sink   (input valid, input allow_html, output ready);
endinterface

FILE: rtl/heu_decide.sv
// heu_decide: lookahead window and per-transaction escape decisions.
// Depends on heu_pkg and heu_in_if.
`timescale 1ns / 1ps

module heu_decide
    import heu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_allow_html,
    input  logic        i_take_ok,
    heu_in_if.sink      i_in,
    output t_step_rec   o_rec,
    output logic        o_load
);

    logic [WIN_DEPTH-1:0][7:0] r_win;
    logic [1:0]                r_fill;
    logic [WIN_DEPTH-1:0][7:0] n_win;
    logic [1:0]                n_fill;

    logic [SEQ_LEN-1:0][7:0] seq;
    logic [2:0]              num;
    logic [2:0]              stop;
    logic                    found;
    logic                    tail_ok;
    logic                    full_look;
    logic                    is_last;
    logic [2:0]              cnt;
    logic                    drop;
    t_kind                   kind;
    t_step_rec               rec;
    logic                    accept;

    assign i_in.ready = i_take_ok;
    assign accept     = i_in.valid && i_take_ok;
    assign is_last    = i_in.last_byte;

    // held window bytes followed by the new byte
    always_comb begin
        seq[0] = (r_fill == 2'd0) ? i_in.data_byte : r_win[0];
        seq[1] = (r_fill == 2'd1) ? i_in.data_byte : r_win[1];
        seq[2] = (r_fill == 2'd2) ? i_in.data_byte : r_win[2];
        seq[3] = i_in.data_byte;
        num    = 3'({1'b0, r_fill}) + 3'd1;
    end

    // a head ampersand sees a full lookahead only when all four bytes are present
    assign full_look = (num == 3'd4);
    assign tail_ok   = (seq[1] == CH_L || seq[1] == CH_G) && seq[2] == CH_T
                       && seq[3] == CH_SEMI;

    // first ampersand that still lacks its lookahead
    always_comb begin
        stop  = num;
        found = 1'b0;
        for (int k = 0; k < SEQ_LEN; k++) begin
            if (!found && 3'(k) < num && seq[k] == CH_AMP && !i_allow_html && !is_last
                && !(k == 0 && full_look)) begin
                stop  = 3'(k);
                found = 1'b1;
            end
        end
    end

    // classify the decided bytes and pack the non-dropped ones
    always_comb begin
        rec      = '0;
        rec.last = is_last;
        cnt      = 3'd0;
        kind     = K_PLAIN;
        drop     = 1'b0;
        for (int k = 0; k < SEQ_LEN; k++) begin
            drop = 1'b0;
            kind = K_PLAIN;
            if (seq[k] == CH_AMP && !i_allow_html) begin
                kind = (k == 0 && full_look && tail_ok) ? K_PLAIN : K_AMP;
            end else if (seq[k] == CH_LT && !i_allow_html) begin
                kind = K_LT;
            end else if (seq[k] == CH_GT && !i_allow_html) begin
                kind = K_GT;
            end else if (seq[k] == CH_QUOT) begin
                kind = K_QUOT;
            end else if (seq[k] == CH_APOS) begin
                kind = K_APOS;
            end else if (seq[k] < CH_SPACE && seq[k] != CH_TAB && seq[k] != CH_LF
                         && seq[k] != CH_CR) begin
                drop = 1'b1;
            end
            if (3'(k) < stop && !drop) begin
                rec.kind[cnt[1:0]] = kind;
                rec.chr[cnt[1:0]]  = seq[k];
                cnt                = cnt + 3'd1;
            end
        end
        rec.cnt = cnt;
    end

    // undecided bytes stay in the window
    always_comb begin
        for (int j = 0; j < WIN_DEPTH; j++) begin
            n_win[j] = seq[2'(stop + 3'(j))];
        end
        n_fill = is_last ? 2'd0 : 2'(num - stop);
    end

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    // a record goes out when there is output or the string ends
    assign o_rec  = rec;
    assign o_load = accept && (cnt != 3'd0 || is_last);

endmodule

FILE: rtl/heu_serial.sv
// heu_serial: token record register and output byte register; expands
// tokens into entity text one byte per cycle while the output is ready. Depends on heu_pkg and heu_out_if.
`timescale 1ns / 1ps

module heu_serial
    import heu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_step_rec  i_rec,
    input  logic       i_load,
    output logic       o_take_ok,
    heu_out_if.source  o_out
);

    t_step_rec  r_rec;
    logic       r_busy;
    logic [1:0] r_tok_idx;
    logic [2:0] r_chr_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_has;
    logic       r_out_end;

    t_kind      cur_kind;
    logic [7:0] cur_chr;
    logic [2:0] cur_len;
    logic       last_tok;
    logic       last_chr;
    logic       bare;
    logic       done;
    logic       emit;

    // current token and position in its expansion
    assign cur_kind = r_rec.kind[r_tok_idx];
    assign cur_chr  = r_rec.chr[r_tok_idx];
    assign cur_len  = ent_len(cur_kind);
    assign last_tok = ({1'b0, r_tok_idx} == 3'(r_rec.cnt - 3'd1));
    assign last_chr = (r_chr_idx == 3'(cur_len - 3'd1));
    assign bare     = r_rec.last && (r_rec.cnt == 3'd0);
    assign done     = bare || (last_tok && last_chr);

    assign emit      = r_busy && (!r_out_valid || o_out.ready);
    assign o_take_ok = !r_busy || (emit && done);

    // record register and expansion counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (emit && done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec     <= i_rec;
            r_tok_idx <= 2'd0;
            r_chr_idx <= 3'd0;
        end else if (emit && !done) begin
            if (last_chr) begin
                r_tok_idx <= r_tok_idx + 2'd1;
                r_chr_idx <= 3'd0;
            end else begin
                r_chr_idx <= r_chr_idx + 3'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= bare ? 8'h00 : ent_char(cur_kind, r_chr_idx, cur_chr);
            r_out_has  <= !bare;
            r_out_end  <= r_rec.last && done;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.has_byte      = r_out_has;
    assign o_out.end_of_string = r_out_end;

endmodule

FILE: rtl/html_entity_escaper_unit.sv
// html_entity_escaper_unit: top level of the streaming html entity escaper.
// Depends on heu_pkg, the heu_*_if interfaces, heu_decide and heu_serial.
`timescale 1ns / 1ps

// Escapes a byte stream for html: '<' and '>' become &lt; and &gt;, '&' becomes
// &amp; unless followed by "lt;" or "gt;", quotes become &quot; and &#39;, and
// control bytes other than tab, LF and CR are dropped. Setting allow_html leaves
// angle brackets and ampersands untouched. An ampersand is held until three more
// bytes of the same string arrive or the string ends. Output is one byte per
// cycle while the receiver is ready, through a registered output stage, and
// the input is held until the previous transaction's last byte is emitted.
// A string whose final transaction yields nothing ends with a bare marker
// (has_byte low, end_of_string high). Write allow_html only while the block is
// idle; it resets to 0.

module html_entity_escaper_unit
    import heu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    heu_cfg_if.sink   i_cfg,
    heu_in_if.sink    i_in,
    heu_out_if.source o_out
);

    logic      r_allow_html;
    t_step_rec rec;
    logic      load;
    logic      take_ok;

    // configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_html <= 1'b0;
        end else if (i_cfg.valid) begin
            r_allow_html <= i_cfg.allow_html;
        end
    end

    // window and decisions
    heu_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_allow_html (r_allow_html),
        .i_take_ok    (take_ok),
        .i_in         (i_in),
        .o_rec        (rec),
        .o_load       (load)
    );

    // entity expansion and output register
    heu_serial u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rec     (rec),
        .i_load    (load),
        .o_take_ok (take_ok),
        .o_out     (o_out)
    );

endmodule
